// File: rtl/core/shpt_pkg.sv
// Shared types, constants and helpers for the sampled hash position table.
package shpt_pkg;

   localparam int KEY_W     = 32;
   localparam int POS_W     = 48;
   localparam int QUAL_W    = 16;
   localparam int OP_W      = 2;
   localparam int MOD_W     = 14;
   localparam int SAMPLE_W  = 11;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SLOT_COUNT_DEFAULT = 8192;

   localparam logic [MOD_W-1:0]    MODULUS_RST = 14'd8191;
   localparam logic [SAMPLE_W-1:0] SAMPLE_RST  = 11'd32;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE  = 2'd1;

   localparam int STEP_LIMIT = 4;
   localparam int DROP_GOOD  = 4;
   localparam int DROP_POOR  = 1;
   localparam int RANGE_STEP = 4;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [KEY_W-1:0]  hash_key;
      logic [POS_W-1:0]  position;
      logic [QUAL_W-1:0] quality;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  found_position;
      logic              stored;
      logic [CNT_W-1:0]  hit_total;
      logic [CNT_W-1:0]  reliability_range;
   } rsp_type;

   // Starting reliability range: sample size plus half of it.
   function automatic logic [CNT_W-1:0] reliability_start(input logic [SAMPLE_W-1:0] sample);
      logic [SAMPLE_W:0] sum;
      sum = {1'b0, sample} + {2'b0, sample[SAMPLE_W-1:1]};
      return CNT_W'(sum);
   endfunction

endpackage

// File: rtl/core/sampled_hash_position_table.sv
// Top level of the sampled hash position table.
//
//   port group  direction  handshake            payload
//   req_        in         req_valid/req_ready  req_data (opcode, key, position, quality)
//   rsp_        out        rsp_valid/rsp_ready  rsp_data (found, position, stored, totals)
//   csr_        in         csr_valid/csr_ready  csr_index, csr_data
//
// A response follows its request through the bit-serial modulo unit, the queue,
// a memory read and an update step.  The modulo unit handles one key at a time,
// so a new request is taken only after the previous key has entered the queue;
// the back end reads the slot memories at one address and writes at one.
// After reset a sweep zeroes all SLOT_COUNT slots, and no request is accepted
// until it ends.  A waiting response stalls only the back end; the front end
// keeps reducing the next key meanwhile until the queue fills.
module sampled_hash_position_table #(
   parameter int SLOT_COUNT = shpt_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  shpt_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output shpt_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [shpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [shpt_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int REQ_W  = $bits(shpt_pkg::req_type);
   localparam int ITEM_W = REQ_W + IDX_W;
   localparam int MOD_MAX = (1 << shpt_pkg::MOD_W) - 1;
   localparam int SLOT_CAP = (SLOT_COUNT > MOD_MAX) ? MOD_MAX : SLOT_COUNT;

   logic [shpt_pkg::MOD_W-1:0]    modulus_ff;
   logic [shpt_pkg::SAMPLE_W-1:0] sample_ff;
   logic [shpt_pkg::MOD_W-1:0]    eff_mod;
   logic                          clear_busy;
   logic                          queue_full;
   logic                          queue_empty;
   logic                          push_valid;
   shpt_pkg::req_type             push_req;
   logic [IDX_W-1:0]              push_idx;
   logic                          pop;
   logic [ITEM_W-1:0]             head_data;
   shpt_pkg::req_type             head_req;
   logic [IDX_W-1:0]              head_idx;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= shpt_pkg::MODULUS_RST;
         sample_ff  <= shpt_pkg::SAMPLE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            shpt_pkg::CSR_MODULUS: modulus_ff <= csr_data[shpt_pkg::MOD_W-1:0];
            shpt_pkg::CSR_SAMPLE:  sample_ff  <= csr_data[shpt_pkg::SAMPLE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamp the modulus to the populated slot range; a zero modulus becomes one
   always_comb begin
      if (modulus_ff == '0) begin
         eff_mod = shpt_pkg::MOD_W'(1);
      end else if (modulus_ff > shpt_pkg::MOD_W'(SLOT_CAP)) begin
         eff_mod = shpt_pkg::MOD_W'(SLOT_CAP);
      end else begin
         eff_mod = modulus_ff;
      end
   end

   shpt_front #(
      .IDX_W (IDX_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .eff_mod    (eff_mod),
      .clear_busy (clear_busy),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_req   (push_req),
      .push_idx   (push_idx)
   );

   shpt_queue #(
      .DATA_W (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  ({push_req, push_idx}),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .head_data  (head_data)
   );

   assign head_req = head_data[ITEM_W-1:IDX_W];
   assign head_idx = head_data[IDX_W-1:0];

   shpt_back #(
      .SLOT_COUNT (SLOT_COUNT),
      .IDX_W      (IDX_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .eff_mod     (eff_mod),
      .sample_size (sample_ff),
      .queue_empty (queue_empty),
      .head_req    (head_req),
      .head_idx    (head_idx),
      .pop         (pop),
      .clear_busy  (clear_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// File: rtl/core/shpt_front.sv
// Front end: accepts requests and reduces the key modulo the clamped modulus, one bit a cycle.
module shpt_front #(
   parameter int IDX_W = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  shpt_pkg::req_type            req_data,
   input  logic [shpt_pkg::MOD_W-1:0]   eff_mod,
   input  logic                         clear_busy,
   input  logic                         queue_full,
   output logic                         push_valid,
   output shpt_pkg::req_type            push_req,
   output logic [IDX_W-1:0]             push_idx
);

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_type;

   localparam int BIT_W = $clog2(shpt_pkg::KEY_W);

   fstate_type                   state_ff;
   shpt_pkg::req_type            req_ff;
   logic [shpt_pkg::MOD_W-1:0]   rem_ff;
   logic [shpt_pkg::MOD_W-1:0]   rem_in;
   logic [BIT_W-1:0]             bit_ff;
   logic [shpt_pkg::MOD_W:0]     trial;

   always_comb begin
      trial = {rem_ff, req_ff.hash_key[bit_ff]};
      if (trial >= {1'b0, eff_mod}) begin
         trial = trial - {1'b0, eff_mod};
      end
      rem_in = trial[shpt_pkg::MOD_W-1:0];
   end

   assign req_ready  = (state_ff == F_IDLE) && !clear_busy;
   assign push_valid = (state_ff == F_PUSH);
   assign push_req   = req_ff;
   assign push_idx   = IDX_W'(rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff   <= req_data;
                  rem_ff   <= '0;
                  bit_ff   <= BIT_W'(shpt_pkg::KEY_W - 1);
                  state_ff <= F_DIV;
               end
            end
            F_DIV: begin
               rem_ff <= rem_in;
               if (bit_ff == '0) begin
                  state_ff <= F_PUSH;
               end else begin
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            F_PUSH: begin
               // hold until the queue has room
               if (!queue_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

// File: rtl/core/shpt_queue.sv
// Two-entry queue between the front end and the table back end.
module shpt_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] head_data
);

   logic [DATA_W-1:0] slots_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_data = slots_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && !empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// File: rtl/core/shpt_back.sv
// Back end: slot memories, clearing sweep, sampling counters and the response register.
module shpt_back #(
   parameter int SLOT_COUNT = shpt_pkg::SLOT_COUNT_DEFAULT,
   parameter int IDX_W      = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [shpt_pkg::MOD_W-1:0]    eff_mod,
   input  logic [shpt_pkg::SAMPLE_W-1:0] sample_size,
   input  logic                          queue_empty,
   input  shpt_pkg::req_type             head_req,
   input  logic [IDX_W-1:0]              head_idx,
   output logic                          pop,
   output logic                          clear_busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output shpt_pkg::rsp_type             rsp_data
);

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} bstate_type;

   localparam int CW = shpt_pkg::CNT_W;
   localparam int LOAD_RST_INT =
      (int'(shpt_pkg::MODULUS_RST) > SLOT_COUNT) ? SLOT_COUNT : int'(shpt_pkg::MODULUS_RST);
   localparam logic [shpt_pkg::MOD_W-1:0] LOAD_RST = shpt_pkg::MOD_W'(LOAD_RST_INT);
   localparam logic [CW-1:0] MAX_CNT = '1;

   logic [shpt_pkg::KEY_W-1:0] key_mem [SLOT_COUNT];
   logic [shpt_pkg::POS_W-1:0] pos_mem [SLOT_COUNT];

   bstate_type                  state_ff;
   logic [IDX_W-1:0]            clr_idx_ff;
   shpt_pkg::req_type           item_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [shpt_pkg::KEY_W-1:0]  key_rd_ff;
   logic [shpt_pkg::POS_W-1:0]  pos_rd_ff;
   logic [shpt_pkg::MOD_W-1:0]  load_ff;
   logic [shpt_pkg::MOD_W-1:0]  load_in;
   logic [CW-1:0]               limit_ff;
   logic [CW-1:0]               limit_in;
   logic signed [CW:0]          ovr_ff;
   logic signed [CW:0]          ovr_in;
   logic signed [CW:0]          ovr_dec;
   logic [CW-1:0]               rel_ff;
   logic [CW-1:0]               rel_in;
   logic [CW-1:0]               hit_ff;
   logic [CW-1:0]               hit_in;
   logic                        rsp_valid_ff;
   shpt_pkg::rsp_type           rsp_ff;
   shpt_pkg::rsp_type           rsp_in;
   logic [CW:0]                 limit_sum;
   logic [CW:0]                 rel_sum;
   logic                        good;
   logic                        do_store;
   logic                        mem_we;
   logic [IDX_W-1:0]            mem_addr;

   assign clear_busy = (state_ff == B_CLEAR);
   assign pop        = (state_ff == B_IDLE) && !queue_empty && !rsp_valid_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      load_in   = load_ff;
      limit_in  = limit_ff;
      ovr_in    = ovr_ff;
      rel_in    = rel_ff;
      hit_in    = hit_ff;
      do_store  = 1'b0;
      limit_sum = {1'b0, limit_ff} + (CW+1)'(shpt_pkg::STEP_LIMIT);
      rel_sum   = {1'b0, rel_ff} + (CW+1)'(shpt_pkg::RANGE_STEP);
      good      = {1'b0, item_ff.quality} <= {5'b0, sample_size, 1'b0};
      ovr_dec   = ovr_ff;
      rsp_in    = '0;
      case (item_ff.opcode)
         shpt_pkg::OP_ADD: begin
            if (load_ff != '0) begin
               load_in = load_ff - 1'b1;
            end else begin
               // countdown ran out: reload and widen the limits
               load_in  = eff_mod;
               limit_in = limit_sum[CW] ? MAX_CNT : limit_sum[CW-1:0];
               rel_in   = rel_sum[CW] ? MAX_CNT : rel_sum[CW-1:0];
            end
            ovr_dec = ovr_ff - (good ? (CW+1)'(shpt_pkg::DROP_GOOD)
                                     : (CW+1)'(shpt_pkg::DROP_POOR));
            do_store = (ovr_dec <= 0);
            ovr_in   = do_store ? $signed({1'b0, limit_in}) : ovr_dec;
            rsp_in.stored = do_store;
         end
         shpt_pkg::OP_LOOKUP: begin
            if (key_rd_ff == item_ff.hash_key) begin
               hit_in = (hit_ff == MAX_CNT) ? hit_ff : hit_ff + 1'b1;
               rsp_in.found          = 1'b1;
               rsp_in.found_position = pos_rd_ff;
            end
         end
         shpt_pkg::OP_RESET: begin
            load_in  = eff_mod;
            limit_in = CW'(shpt_pkg::STEP_LIMIT);
            ovr_in   = (CW+1)'(shpt_pkg::STEP_LIMIT);
            rel_in   = shpt_pkg::reliability_start(sample_size);
         end
         default: begin
         end
      endcase
      rsp_in.hit_total         = hit_in;
      rsp_in.reliability_range = rel_in;
   end

   assign mem_we   = (state_ff == B_CLEAR) || ((state_ff == B_EXEC) && do_store);
   assign mem_addr = (state_ff == B_CLEAR) ? clr_idx_ff : idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_addr] <= (state_ff == B_CLEAR) ? '0 : item_ff.hash_key;
         pos_mem[mem_addr] <= (state_ff == B_CLEAR) ? '0 : item_ff.position;
      end
      key_rd_ff <= key_mem[head_idx];
      pos_rd_ff <= pos_mem[head_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_idx_ff   <= '0;
         load_ff      <= LOAD_RST;
         limit_ff     <= CW'(shpt_pkg::STEP_LIMIT);
         ovr_ff       <= (CW+1)'(shpt_pkg::STEP_LIMIT);
         rel_ff       <= shpt_pkg::reliability_start(shpt_pkg::SAMPLE_RST);
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_CLEAR: begin
               if (clr_idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
                  state_ff <= B_IDLE;
               end else begin
                  clr_idx_ff <= clr_idx_ff + 1'b1;
               end
            end
            B_IDLE: begin
               if (pop) begin
                  item_ff  <= head_req;
                  idx_ff   <= head_idx;
                  state_ff <= B_EXEC;
               end
            end
            B_EXEC: begin
               load_ff      <= load_in;
               limit_ff     <= limit_in;
               ovr_ff       <= ovr_in;
               rel_ff       <= rel_in;
               hit_ff       <= hit_in;
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= 1'b1;
               state_ff     <= B_IDLE;
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule
